@@ design/gbim_pkg.sv @@
// ----------------------------------------------------------------------------
// gbim_pkg
// shared constants, codes and command/status types of the box matcher
// ----------------------------------------------------------------------------
package gbim_pkg;

  localparam int MaxSegments = 16;
  localparam int SegIdxW     = $clog2(MaxSegments);
  localparam int SegCntW     = $clog2(MaxSegments + 1);

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_MATCH  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] ST_MATCHED  = 2'd0;
  localparam logic [1:0] ST_NO_MATCH = 2'd1;
  localparam logic [1:0] ST_SMALL    = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  localparam logic [1:0] CFG_IOU   = 2'd0;
  localparam logic [1:0] CFG_DIST  = 2'd1;
  localparam logic [1:0] CFG_MINW  = 2'd2;
  localparam logic [1:0] CFG_MINH  = 2'd3;

  typedef struct packed {
    logic                load;     // capture the input item
    logic                clear;
    logic                add;
    logic                scan_start;
    logic                scan_step;  // evaluate entry at scan index
    logic                pass2;      // fallback distance pass
    logic                div_start;
    logic                finish;     // build result
  } gbim_cmd_t;

  typedef struct packed {
    logic                box_valid;
    logic                table_full;
    logic                scan_last;
    logic                cand;       // evaluated entry is unused and stored
    logic                div_done;
    logic                found;
  } gbim_sts_t;

endpackage

@@ design/gbim_divider.sv @@
// ----------------------------------------------------------------------------
// gbim_divider
// restoring divider, one quotient bit per cycle, 48 by 33 bit
// ----------------------------------------------------------------------------
module gbim_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);
  logic [33:0] rem;
  logic [47:0] quo;
  logic [32:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] trial;
  logic [33:0] sh;

  assign sh    = {rem[32:0], quo[47]};
  assign trial = sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd48;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[33]) begin
        rem <= trial;
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= sh;
        quo <= {quo[46:0], 1'b0};
      end
    end
  end

  assign quotient = quo;
endmodule

@@ design/gbim_datapath.sv @@
// ----------------------------------------------------------------------------
// gbim_datapath
// segment table, iou and center distance evaluation, best tracking, result
// ----------------------------------------------------------------------------
module gbim_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  gbim_pkg::gbim_cmd_t     cmd,
  output gbim_pkg::gbim_sts_t     sts,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_idx,
  input  logic [15:0]             cfg_data,
  input  logic [15:0]             in_left,
  input  logic [15:0]             in_top,
  input  logic [15:0]             in_right,
  input  logic [15:0]             in_bottom,
  input  logic [7:0]              in_det,
  input  logic [7:0]              in_plane,
  input  logic [15:0]             in_track,
  output logic [1:0]              r_status,
  output logic [7:0]              r_player,
  output logic [15:0]             r_track,
  output logic [7:0]              r_seg,
  output logic [7:0]              r_plane,
  output logic [12:0]             r_cl,
  output logic [12:0]             r_ct,
  output logic [12:0]             r_cr,
  output logic [12:0]             r_cb
);
  localparam int IW = gbim_pkg::SegIdxW;
  localparam int CW = gbim_pkg::SegCntW;

  logic [15:0] thr, fdist;
  logic [12:0] minw, minh;

  logic [63:0] boxes [gbim_pkg::MaxSegments];
  logic [15:0] ids   [gbim_pkg::MaxSegments];
  logic [gbim_pkg::MaxSegments-1:0] used;
  logic [CW-1:0] count;

  logic [15:0] pl, pt, pr, pb;
  logic [7:0]  pdet, pplane;
  logic [15:0] ptrk;

  logic [IW-1:0] idx;
  logic [63:0] ent;
  logic        ent_ok;

  logic [15:0] sl, st, sr, sb;
  logic [15:0] ix1, iy1, ix2, iy2, iw, ih;
  logic [31:0] inter_c, area_a, area_b;
  logic [31:0] inter_r;
  logic [32:0] uni_r;
  logic [16:0] acx, acy, bcx, bcy, dx, dy;
  logic [33:0] dxsq, dysq;
  logic [34:0] dsq_r;
  logic        cand_r;
  logic [IW-1:0] cand_idx;

  logic        div_done;
  logic [47:0] quo;
  logic [16:0] fd2;
  logic [33:0] lim_sq;
  logic [34:0] lim;

  logic        found;
  logic [IW-1:0] best;
  logic [16:0] top_iou;
  logic [34:0] best_d;

  logic        iou_hit;
  logic        ucapt;
  logic [16:0] qv;

  logic [63:0] bb;
  logic [15:0] bid;
  logic [12:0] cl, ct, cr, cb;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr   <= 16'd9830;
      fdist <= 16'd960;
      minw  <= 13'd8;
      minh  <= 13'd8;
    end else if (cfg_we) begin
      case (cfg_idx)
        gbim_pkg::CFG_IOU:  thr   <= cfg_data;
        gbim_pkg::CFG_DIST: fdist <= cfg_data;
        gbim_pkg::CFG_MINW: minw  <= cfg_data[12:0];
        gbim_pkg::CFG_MINH: minh  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pl <= in_left; pt <= in_top; pr <= in_right; pb <= in_bottom;
      pdet <= in_det; pplane <= in_plane; ptrk <= in_track;
    end
    if (cmd.add) begin
      boxes[count[IW-1:0]] <= {pl, pt, pr, pb};
      ids[count[IW-1:0]]   <= {pdet, pplane};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      count <= '0;
    end else if (cmd.clear) begin
      used  <= '0;
      count <= '0;
    end else if (cmd.add) begin
      used[count[IW-1:0]] <= 1'b0;
      count <= count + CW'(1);
    end else if (cmd.finish && found) begin
      used[best] <= 1'b1;
    end
  end

  assign sts.box_valid  = (pr > pl) && (pb > pt);
  assign sts.table_full = (count == CW'(gbim_pkg::MaxSegments));
  assign sts.scan_last  = ({1'b0, idx} + CW'(1) >= count);
  assign sts.cand       = cand_r;
  assign sts.div_done   = div_done;
  assign sts.found      = found;

  // entry read and first stage
  assign ent    = boxes[idx];
  assign ent_ok = ({1'b0, idx} < count) && !used[idx];
  assign sl = ent[63:48]; assign st = ent[47:32];
  assign sr = ent[31:16]; assign sb = ent[15:0];
  assign ix1 = (pl > sl) ? pl : sl;
  assign iy1 = (pt > st) ? pt : st;
  assign ix2 = (pr < sr) ? pr : sr;
  assign iy2 = (pb < sb) ? pb : sb;
  assign iw  = (ix2 > ix1) ? ix2 - ix1 : '0;
  assign ih  = (iy2 > iy1) ? iy2 - iy1 : '0;
  assign inter_c = iw * ih;
  assign area_a  = (pr - pl) * (pb - pt);
  assign area_b  = (sr - sl) * (sb - st);
  assign acx = {1'b0, pl} + {1'b0, pr};
  assign acy = {1'b0, pt} + {1'b0, pb};
  assign bcx = {1'b0, sl} + {1'b0, sr};
  assign bcy = {1'b0, st} + {1'b0, sb};
  assign dx  = (acx > bcx) ? acx - bcx : bcx - acx;
  assign dy  = (acy > bcy) ? acy - bcy : bcy - acy;
  assign dxsq = dx * dx;
  assign dysq = dy * dy;

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      inter_r  <= inter_c;
      uni_r    <= {1'b0, area_a} + {1'b0, area_b} - {1'b0, inter_c};
      dsq_r    <= {1'b0, dxsq} + {1'b0, dysq};
      cand_idx <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cand_r <= 1'b0;
    else     cand_r <= cmd.scan_step && ent_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) idx <= '0;
    else if (cmd.scan_start) idx <= '0;
    else if (cmd.scan_step && !sts.scan_last) idx <= idx + IW'(1);
  end

  gbim_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start && cand_r),
    .dividend({inter_r, 16'd0}), .divisor((uni_r == '0) ? 33'd1 : uni_r),
    .done(div_done), .quotient(quo)
  );

  assign fd2    = {fdist, 1'b0};
  assign lim_sq = fd2 * fd2;
  assign lim    = {1'b0, lim_sq};

  assign ucapt   = (uni_r != '0);
  assign qv      = ucapt ? quo[16:0] : 17'd0;
  assign iou_hit = (qv >= {1'b0, thr}) && (qv > top_iou);

  always_ff @(posedge clk) begin
    if (rst) begin
      found   <= 1'b0;
      top_iou <= '0;
      best_d  <= '0;
    end else if (cmd.scan_start && !cmd.pass2) begin
      found   <= 1'b0;
      top_iou <= '0;
    end else if (cmd.scan_start) begin
      best_d <= lim;
    end else if (!cmd.pass2 && div_done && iou_hit) begin
      top_iou <= qv; best <= cand_idx; found <= 1'b1;
    end else if (cmd.pass2 && cand_r && (dsq_r <= best_d)) begin
      best_d <= dsq_r; best <= cand_idx; found <= 1'b1;
    end
  end

  assign bb  = boxes[best];
  assign bid = ids[best];
  assign cl  = {1'b0, bb[63:52]};
  assign ct  = {1'b0, bb[47:36]};
  assign cr  = 13'(({1'b0, bb[31:16]} + 17'd15) >> 4);
  assign cb  = 13'(({1'b0, bb[15:0]} + 17'd15) >> 4);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      r_player <= pdet;
      r_track  <= ptrk;
      if (!sts.box_valid || !found) begin
        r_status <= sts.box_valid ? gbim_pkg::ST_NO_MATCH : gbim_pkg::ST_INVALID;
        r_seg <= '0; r_plane <= '0;
        r_cl <= '0; r_ct <= '0; r_cr <= '0; r_cb <= '0;
      end else begin
        r_seg <= bid[15:8]; r_plane <= bid[7:0];
        r_cl <= cl; r_ct <= ct; r_cr <= cr; r_cb <= cb;
        r_status <= ((cr - cl < minw) || (cb - ct < minh)) ?
                    gbim_pkg::ST_SMALL : gbim_pkg::ST_MATCHED;
      end
    end
  end
endmodule

@@ design/gbim_control.sv @@
// ----------------------------------------------------------------------------
// gbim_control
// request sequencer: iou scan pass over the table, distance pass if nothing matched, result handoff
// ----------------------------------------------------------------------------
module gbim_control (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_req,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output gbim_pkg::gbim_cmd_t cmd,
  input  gbim_pkg::gbim_sts_t sts
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_STEP1 = 4'd2,
    S_EVAL1 = 4'd3, S_DIV = 4'd4, S_PASS2 = 4'd5, S_STEP2 = 4'd6,
    S_EVAL2 = 4'd7, S_FIN = 4'd8, S_OUT = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] req;
  logic       last;
  logic       ov_next;

  assign in_stall = rst || (state != S_IDLE) || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
    end else begin
      state <= state_next; out_valid <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req <= in_req;
    if (cmd.scan_step) last <= sts.scan_last;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    ov_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load = 1'b1; state_next = S_DEC;
        end
      end
      S_DEC: begin
        state_next = S_IDLE;
        case (req)
          gbim_pkg::REQ_CLEAR: cmd.clear = 1'b1;
          gbim_pkg::REQ_ADD: cmd.add = sts.box_valid && !sts.table_full;
          gbim_pkg::REQ_MATCH: begin
            cmd.scan_start = 1'b1;
            state_next = sts.box_valid ? S_STEP1 : S_FIN;
          end
          default: ;
        endcase
      end
      S_STEP1: begin cmd.scan_step = 1'b1; state_next = S_EVAL1; end
      S_EVAL1: begin
        if (sts.cand) begin
          cmd.div_start = 1'b1; state_next = S_DIV;
        end else begin
          state_next = last ? S_PASS2 : S_STEP1;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = last ? S_PASS2 : S_STEP1;
      end
      S_PASS2: begin
        if (sts.found) begin
          state_next = S_FIN;
        end else begin
          cmd.pass2 = 1'b1; cmd.scan_start = 1'b1; state_next = S_STEP2;
        end
      end
      S_STEP2: begin
        cmd.pass2 = 1'b1; cmd.scan_step = 1'b1; state_next = S_EVAL2;
      end
      S_EVAL2: begin
        cmd.pass2 = 1'b1;
        state_next = last ? S_FIN : S_STEP2;
      end
      S_FIN: begin cmd.finish = 1'b1; state_next = S_OUT; end
      S_OUT: begin
        if (!(out_valid && out_stall)) begin
          ov_next = 1'b1; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

@@ design/greedy_box_iou_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// greedy_box_iou_matcher_unit
// greedy iou box association against a table of segment boxes
// ----------------------------------------------------------------------------
// clear and add end in the decode state; an invalid player box skips both passes
// and goes straight to the result; a match visits every table entry (at least
// one) in the iou pass, runs the 48-bit serial divide for each unused entry, and
// visits every entry again in the distance pass when nothing reaches the
// threshold; one transaction at a time, input stalled while a result waits
// reset sets registers to defaults and empties the table at once
module greedy_box_iou_matcher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [15:0] box_left,
  input  logic [15:0] box_top,
  input  logic [15:0] box_right,
  input  logic [15:0] box_bottom,
  input  logic [7:0]  detection_index,
  input  logic [7:0]  mask_plane,
  input  logic [15:0] track_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  player_index,
  output logic [15:0] track_out,
  output logic [7:0]  segment_index,
  output logic [7:0]  segment_plane,
  output logic [12:0] crop_left,
  output logic [12:0] crop_top,
  output logic [12:0] crop_right,
  output logic [12:0] crop_bottom,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  gbim_pkg::gbim_cmd_t cmd;
  gbim_pkg::gbim_sts_t sts;

  gbim_control u_ctl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_req(req_type),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts)
  );

  gbim_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .in_left(box_left), .in_top(box_top), .in_right(box_right),
    .in_bottom(box_bottom), .in_det(detection_index), .in_plane(mask_plane),
    .in_track(track_number),
    .r_status(status), .r_player(player_index), .r_track(track_out),
    .r_seg(segment_index), .r_plane(segment_plane),
    .r_cl(crop_left), .r_ct(crop_top), .r_cr(crop_right), .r_cb(crop_bottom)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result stalled");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("stalled result changed");
endmodule

@@ tb/gbim_checker.sv @@
// ----------------------------------------------------------------------------
// gbim_checker
// watches the request and result channels of the box matcher, keeps its own
// copy of the segment table and registers, predicts each match result and
// compares it field by field against what the block returns
// ----------------------------------------------------------------------------
module gbim_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [15:0] box_left,
  input  logic [15:0] box_top,
  input  logic [15:0] box_right,
  input  logic [15:0] box_bottom,
  input  logic [7:0]  detection_index,
  input  logic [7:0]  mask_plane,
  input  logic [15:0] track_number,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [7:0]  player_index,
  input  logic [15:0] track_out,
  input  logic [7:0]  segment_index,
  input  logic [7:0]  segment_plane,
  input  logic [12:0] crop_left,
  input  logic [12:0] crop_top,
  input  logic [12:0] crop_right,
  input  logic [12:0] crop_bottom,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending_matches,
  output int          match_count
);

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  player;
    logic [15:0] track;
    logic [7:0]  seg;
    logic [7:0]  plane;
    logic [12:0] cl, ct, cr, cb;
  } match_result_t;

  match_result_t expected_results[$];

  logic [15:0] thr_q16, dist_lim;
  logic [12:0] min_w, min_h;
  logic [15:0] tbl_box [gbim_pkg::MaxSegments][4];
  logic [7:0]  tbl_det [gbim_pkg::MaxSegments];
  logic [7:0]  tbl_plane [gbim_pkg::MaxSegments];
  logic        tbl_used [gbim_pkg::MaxSegments];
  int          tbl_count;

  function automatic logic [63:0] overlap_q16(logic [15:0] a [4], int s);
    logic [31:0] ix1, iy1, ix2, iy2;
    logic [63:0] inter, uni, area_a, area_b;
    ix1 = (a[0] > tbl_box[s][0]) ? a[0] : tbl_box[s][0];
    iy1 = (a[1] > tbl_box[s][1]) ? a[1] : tbl_box[s][1];
    ix2 = (a[2] < tbl_box[s][2]) ? a[2] : tbl_box[s][2];
    iy2 = (a[3] < tbl_box[s][3]) ? a[3] : tbl_box[s][3];
    inter = ((ix2 > ix1) ? 64'(ix2 - ix1) : 64'd0) *
            ((iy2 > iy1) ? 64'(iy2 - iy1) : 64'd0);
    area_a = 64'(a[2] - a[0]) * 64'(a[3] - a[1]);
    area_b = 64'(tbl_box[s][2] - tbl_box[s][0]) * 64'(tbl_box[s][3] - tbl_box[s][1]);
    uni = area_a + area_b - inter;
    if (uni == 0) return 64'd0;
    return (inter << 16) / uni;
  endfunction

  function automatic logic [63:0] center_gap_sq(logic [15:0] a [4], int s);
    logic [31:0] ax, ay, bx, by;
    logic [63:0] dx, dy;
    ax = 32'(a[0]) + a[2];
    ay = 32'(a[1]) + a[3];
    bx = 32'(tbl_box[s][0]) + tbl_box[s][2];
    by = 32'(tbl_box[s][1]) + tbl_box[s][3];
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return dx * dx + dy * dy;
  endfunction

  function automatic match_result_t predict_match(logic [15:0] b [4], logic [7:0] det,
                                                  logic [15:0] trk);
    match_result_t r;
    int best;
    logic [63:0] best_v, v, lim;
    logic [31:0] cl, ct, cr, cb;
    r = '0;
    r.player = det;
    r.track = trk;
    if (!(b[2] > b[0] && b[3] > b[1])) begin
      r.status = gbim_pkg::ST_INVALID;
      return r;
    end
    best = -1;
    best_v = 0;
    for (int s = 0; s < tbl_count; s++) begin
      if (!tbl_used[s]) begin
        v = overlap_q16(b, s);
        if (v >= thr_q16 && v > best_v) begin
          best_v = v;
          best = s;
        end
      end
    end
    if (best < 0) begin
      lim = 2 * 64'(dist_lim);
      best_v = lim * lim;
      for (int s = 0; s < tbl_count; s++) begin
        if (!tbl_used[s]) begin
          v = center_gap_sq(b, s);
          if (v <= best_v) begin
            best_v = v;
            best = s;
          end
        end
      end
    end
    if (best < 0) begin
      r.status = gbim_pkg::ST_NO_MATCH;
      return r;
    end
    tbl_used[best] = 1'b1;
    cl = tbl_box[best][0] >> 4;
    ct = tbl_box[best][1] >> 4;
    cr = (32'(tbl_box[best][2]) + 15) >> 4;
    cb = (32'(tbl_box[best][3]) + 15) >> 4;
    r.seg = tbl_det[best];
    r.plane = tbl_plane[best];
    r.cl = cl[12:0];
    r.ct = ct[12:0];
    r.cr = cr[12:0];
    r.cb = cb[12:0];
    r.status = (cr - cl < min_w || cb - ct < min_h) ?
               gbim_pkg::ST_SMALL : gbim_pkg::ST_MATCHED;
    return r;
  endfunction

  assign pending_matches = expected_results.size();

  always @(posedge clk) begin
    logic [15:0] b [4];
    match_result_t got, want;
    if (rst) begin
      thr_q16 <= 16'd9830;
      dist_lim <= 16'd960;
      min_w <= 13'd8;
      min_h <= 13'd8;
      tbl_count = 0;
      for (int s = 0; s < gbim_pkg::MaxSegments; s++) tbl_used[s] = 1'b0;
      expected_results.delete();
      fail_count <= 0;
      match_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gbim_pkg::CFG_IOU:  thr_q16 <= cfg_data;
          gbim_pkg::CFG_DIST: dist_lim <= cfg_data;
          gbim_pkg::CFG_MINW: min_w <= cfg_data[12:0];
          gbim_pkg::CFG_MINH: min_h <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        b[0] = box_left;
        b[1] = box_top;
        b[2] = box_right;
        b[3] = box_bottom;
        case (req_type)
          gbim_pkg::REQ_CLEAR: begin
            tbl_count = 0;
            for (int s = 0; s < gbim_pkg::MaxSegments; s++) tbl_used[s] = 1'b0;
          end
          gbim_pkg::REQ_ADD: begin
            if (b[2] > b[0] && b[3] > b[1] && tbl_count < gbim_pkg::MaxSegments) begin
              tbl_box[tbl_count] = b;
              tbl_det[tbl_count] = detection_index;
              tbl_plane[tbl_count] = mask_plane;
              tbl_used[tbl_count] = 1'b0;
              tbl_count++;
            end
          end
          gbim_pkg::REQ_MATCH: begin
            want = predict_match(b, detection_index, track_number);
            expected_results = {expected_results, want};
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{status, player_index, track_out, segment_index, segment_plane,
                crop_left, crop_top, crop_right, crop_bottom};
        match_count <= match_count + 1;
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (got.status != want.status)
              $error("status exp %0d got %0d", want.status, got.status);
            if (got.player != want.player)
              $error("player_index exp %0d got %0d", want.player, got.player);
            if (got.track != want.track)
              $error("track_out exp %0d got %0d", want.track, got.track);
            if (got.seg != want.seg)
              $error("segment_index exp %0d got %0d", want.seg, got.seg);
            if (got.plane != want.plane)
              $error("segment_plane exp %0d got %0d", want.plane, got.plane);
            if (got.cl != want.cl)
              $error("crop_left exp %0d got %0d", want.cl, got.cl);
            if (got.ct != want.ct)
              $error("crop_top exp %0d got %0d", want.ct, got.ct);
            if (got.cr != want.cr)
              $error("crop_right exp %0d got %0d", want.cr, got.cr);
            if (got.cb != want.cb)
              $error("crop_bottom exp %0d got %0d", want.cb, got.cb);
          end
        end
      end
    end
  end

endmodule

@@ tb/tb_greedy_box_iou_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// tb_greedy_box_iou_matcher_unit
// drives clear/add/match requests and register writes into the box matcher
// with random gaps and result stalls; a checker beside the block predicts
// and compares every match result
// ----------------------------------------------------------------------------
module tb_greedy_box_iou_matcher_unit;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = gbim_pkg::REQ_CLEAR;
  logic [15:0] box_left = '0, box_top = '0, box_right = '0, box_bottom = '0;
  logic [7:0]  detection_index = '0, mask_plane = '0;
  logic [15:0] track_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [7:0]  player_index, segment_index, segment_plane;
  logic [15:0] track_out;
  logic [12:0] crop_left, crop_top, crop_right, crop_bottom;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = gbim_pkg::CFG_IOU;
  logic [15:0] cfg_data = '0;
  int          fail_count, pending_matches, match_count;
  int          sent;
  int          adds_in_frame;

  always #2 clk = ~clk;

  greedy_box_iou_matcher_unit uut (.*);
  gbim_checker checker_i (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(0, 99) < 2) out_stall <= 1'b0;
    else if (match_count % 200 < 60) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 35);
  end

  task automatic send_req(logic [1:0] rq, logic [15:0] l, logic [15:0] t, logic [15:0] r,
                          logic [15:0] b, logic [7:0] det, logic [7:0] pl, logic [15:0] trk);
    int g;
    g = (sent % 300 < 80) ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    box_left <= l;
    box_top <= t;
    box_right <= r;
    box_bottom <= b;
    detection_index <= det;
    mask_plane <= pl;
    track_number <= trk;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    in_valid <= 1'b0;
    while (pending_matches != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random box near a cluster so that overlaps and near centers are common
  task automatic rand_box(output logic [15:0] l, output logic [15:0] t,
                          output logic [15:0] r, output logic [15:0] b);
    int cx, cy, w, h;
    if ($urandom_range(0, 19) == 0) begin
      l = 16'($urandom);
      t = 16'($urandom);
      r = 16'($urandom);
      b = 16'($urandom);
      return;
    end
    cx = $urandom_range(200, 1600);
    cy = $urandom_range(200, 1600);
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200) : $urandom_range(100, 900);
    h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200) : $urandom_range(100, 900);
    l = 16'(cx);
    t = 16'(cy);
    r = 16'(cx + w);
    b = 16'(cy + h);
  endtask

  initial begin
    logic [15:0] l, t, r, b;
    sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed
    send_req(gbim_pkg::REQ_UNUSED, 16'h0010, 0, 16'h0100, 16'h0100, 1, 1, 1);
    send_req(gbim_pkg::REQ_MATCH, 16'h0100, 0, 16'h0200, 16'h0100, 9, 0, 16'hffff);
    send_req(gbim_pkg::REQ_ADD, 16'h0000, 16'h0000, 16'h0400, 16'h0400, 8'hff, 8'hff, 0);
    send_req(gbim_pkg::REQ_ADD, 16'h0100, 16'h0000, 16'h0100, 16'h0400, 3, 3, 0);
    send_req(gbim_pkg::REQ_ADD, 16'hfff0, 16'hfff0, 16'hffff, 16'hffff, 8'h00, 8'h80, 0);
    send_req(gbim_pkg::REQ_ADD, 16'h0011, 16'h0027, 16'h0031, 16'h0049, 8'h55, 8'haa, 0);
    send_req(gbim_pkg::REQ_MATCH, 16'h0000, 16'h0000, 16'h0400, 16'h0400, 8'hff, 0, 16'h0000);
    send_req(gbim_pkg::REQ_MATCH, 16'h0000, 16'h0000, 16'h0400, 16'h0400, 1, 0, 16'h1234);
    send_req(gbim_pkg::REQ_MATCH, 16'hfff0, 16'hfff0, 16'hffff, 16'hffff, 2, 0, 16'hffff);
    send_req(gbim_pkg::REQ_MATCH, 16'h0300, 16'h0300, 16'h0200, 16'h0400, 4, 0, 7);
    send_req(gbim_pkg::REQ_MATCH, 16'h0000, 16'h0400, 16'h0400, 16'h0400, 5, 0, 7);
    send_req(gbim_pkg::REQ_MATCH, 16'h8000, 16'h8000, 16'h9000, 16'h9000, 6, 0, 8);
    send_req(gbim_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 17; i++)
      send_req(gbim_pkg::REQ_ADD, 16'(i * 64), 0, 16'(i * 64 + 64), 16'h0040,
               8'(i), 8'(i), 0);
    send_req(gbim_pkg::REQ_MATCH, 16'h0000, 0, 16'h0040, 16'h0040, 10, 0, 9);
    write_reg(gbim_pkg::CFG_IOU, 16'hffff);
    send_req(gbim_pkg::REQ_MATCH, 16'h0040, 0, 16'h0080, 16'h0040, 11, 0, 9);
    write_reg(gbim_pkg::CFG_DIST, 16'h0000);
    send_req(gbim_pkg::REQ_MATCH, 16'h0080, 0, 16'h00c0, 16'h0040, 12, 0, 9);
    send_req(gbim_pkg::REQ_MATCH, 16'h0081, 0, 16'h00c0, 16'h0040, 13, 0, 9);
    // random phases through several settings
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(gbim_pkg::CFG_IOU, 0); write_reg(gbim_pkg::CFG_DIST, 16'hffff);
                 write_reg(gbim_pkg::CFG_MINW, 0); write_reg(gbim_pkg::CFG_MINH, 0); end
        1: begin write_reg(gbim_pkg::CFG_IOU, 9830); write_reg(gbim_pkg::CFG_DIST, 960);
                 write_reg(gbim_pkg::CFG_MINW, 8); write_reg(gbim_pkg::CFG_MINH, 8); end
        2: begin write_reg(gbim_pkg::CFG_MINW, 16'h1000);
                 write_reg(gbim_pkg::CFG_MINH, 16'h1fff); end
        3: begin write_reg(gbim_pkg::CFG_IOU, 16'h8000); write_reg(gbim_pkg::CFG_DIST, 200);
                 write_reg(gbim_pkg::CFG_MINW, 30); write_reg(gbim_pkg::CFG_MINH, 20); end
        default: begin
          write_reg(gbim_pkg::CFG_IOU, 16'($urandom_range(0, 40000)));
          write_reg(gbim_pkg::CFG_DIST, 16'($urandom_range(0, 3000)));
          write_reg(gbim_pkg::CFG_MINW, 16'($urandom_range(0, 60)));
          write_reg(gbim_pkg::CFG_MINH, 16'($urandom_range(0, 60)));
        end
      endcase
      for (int f = 0; f < 10; f++) begin
        if ($urandom_range(0, 9) != 0)
          send_req(gbim_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
        adds_in_frame = $urandom_range(0, 18);
        for (int k = 0; k < adds_in_frame; k++) begin
          rand_box(l, t, r, b);
          send_req(gbim_pkg::REQ_ADD, l, t, r, b, 8'($urandom), 8'($urandom),
                   16'($urandom));
        end
        for (int k = 0; k < $urandom_range(1, 8); k++) begin
          rand_box(l, t, r, b);
          send_req(($urandom_range(0, 29) == 0) ? gbim_pkg::REQ_UNUSED : gbim_pkg::REQ_MATCH,
                   l, t, r, b, 8'($urandom), 8'($urandom), 16'($urandom));
        end
      end
    end
    in_valid <= 1'b0;
    while (pending_matches != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    $display("covered %0d requests and %0d match results across 8 register settings",
             sent, match_count);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
